FILE: sv/hsfp_pkg.sv
// ----------------------------------------------------------------------------
// hsfp_pkg
// Shared types and constants of the five-point heat stencil: item structs,
// register width and reset value, and the codes that tag in-flight work.
// ----------------------------------------------------------------------------
package hsfp_pkg;

    // Sizes fixed by the item and register formats
    localparam int VAL_W         = 24;
    localparam int SUM_W         = VAL_W + 3;
    localparam int CFG_W         = 11;
    localparam int MAX_COLUMNS_D = 1024;
    localparam int MIN_COLUMNS   = 3;
    localparam logic [CFG_W-1:0] COLUMNS_RST = CFG_W'(64);

    // Item modes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Kind of work carried into the compute stage
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic             frame_end;
    } t_out_item;

    // Decisions made at accept time for the compute stage
    typedef struct packed {
        logic [1:0] kind;
        logic       emit;        // item yields a result
        logic       use_centre;  // pass the centre cell through
        logic       last;        // last drained cell of the frame
    } t_s1_ctrl;

endpackage

FILE: sv/heat_stencil_five_point.sv
// ----------------------------------------------------------------------------
// heat_stencil_five_point
// Five-point heat-diffusion stencil over a row-major grid stream, with two
// line stores in synchronous memories and a four-cell window.
// A result is registered in the stage register, then the output register.
// Throughput: one item per cycle when not stalled; the line stores take
// one read and one write per cycle, with write-first bypass when both hit
// the same column. Reset: synchronous, active low; clears control, window
// and output valid, sets the column count to 64. Line stores are not cleared.
// ----------------------------------------------------------------------------
module heat_stencil_five_point
    import hsfp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);

    logic              accept;
    logic              s1_valid;
    logic              s1_fire;
    t_s1_ctrl          s1_ctrl;
    logic [ADDR_W-1:0] s1_addr;
    logic [VAL_W-1:0]  s1_sample;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  top_rd;
    logic [VAL_W-1:0]  mid_rd;
    logic              store_we;
    logic [VAL_W-1:0]  upper_wd;
    logic [VAL_W-1:0]  middle_wd;

    // Stall while the compute stage holds an item it cannot hand on
    assign o_in_stall = s1_valid && !s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    hsfp_sequencer #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_s1_fire   (s1_fire),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1_ctrl   (s1_ctrl),
        .o_s1_addr   (s1_addr),
        .o_s1_sample (s1_sample)
    );

    hsfp_line_store #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_upper (
        .i_clk (i_clk),
        .i_we  (store_we),
        .i_wa  (s1_addr),
        .i_wd  (upper_wd),
        .i_re  (accept),
        .i_ra  (rd_addr),
        .o_rd  (top_rd)
    );

    hsfp_line_store #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_middle (
        .i_clk (i_clk),
        .i_we  (store_we),
        .i_wa  (s1_addr),
        .i_wd  (middle_wd),
        .i_re  (accept),
        .i_ra  (rd_addr),
        .o_rd  (mid_rd)
    );

    hsfp_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_s1_valid  (s1_valid),
        .i_s1_ctrl   (s1_ctrl),
        .i_s1_sample (s1_sample),
        .i_top       (top_rd),
        .i_mid       (mid_rd),
        .i_out_stall (i_out_stall),
        .o_s1_fire   (s1_fire),
        .o_store_we  (store_we),
        .o_upper_wd  (upper_wd),
        .o_middle_wd (middle_wd),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: sv/hsfp_line_store.sv
// ----------------------------------------------------------------------------
// hsfp_line_store
// One grid row of samples in a synchronous memory. Read data is registered;
// a write to the address being read in the same cycle is passed through.
// ----------------------------------------------------------------------------
module hsfp_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wa,
    input  logic [DATA_W-1:0] i_wd,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_ra,
    output logic [DATA_W-1:0] o_rd
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // Read port, write-first on address match
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_wa == i_ra)) begin
                r_rd <= i_wd;
            end else begin
                r_rd <= r_mem[i_ra];
            end
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: sv/hsfp_sequencer.sv
// ----------------------------------------------------------------------------
// hsfp_sequencer
// Accept-stage control: column and row tracking, drain bookkeeping, line
// store read address, and the stage register that feeds the compute stage.
// ----------------------------------------------------------------------------
module hsfp_sequencer
    import hsfp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_D,
    parameter int ADDR_W      = $clog2(MAX_COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_accept,
    input  t_in_item          i_item,
    input  logic              i_s1_fire,
    output logic [ADDR_W-1:0] o_rd_addr,
    output logic              o_s1_valid,
    output t_s1_ctrl          o_s1_ctrl,
    output logic [ADDR_W-1:0] o_s1_addr,
    output logic [VAL_W-1:0]  o_s1_sample
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int DW = $clog2(MAX_COLUMNS + 2);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]  r_cols;
    logic [ADDR_W-1:0] r_col;
    logic [1:0]        r_rows;
    logic [DW-1:0]     r_drain;
    logic              r_s1_valid;
    t_s1_ctrl          r_s1_ctrl;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [VAL_W-1:0]  r_s1_sample;

    logic [ADDR_W-1:0] n_col;
    logic [1:0]        n_rows;
    logic [DW-1:0]     n_drain;
    t_s1_ctrl          n_ctrl;

    logic [WW-1:0]     cfg_ext;
    logic [WW-1:0]     w_full;
    logic [CW-1:0]     w;
    logic [ADDR_W-1:0] c;
    logic [DW-1:0]     pending;
    logic [DW-1:0]     dl_cur;
    logic [DW-1:0]     dl_next;
    logic [DW-1:0]     k;
    logic [DW:0]       idx_sum;
    logic [DW:0]       idx_wrap;
    logic [CW-1:0]     c_inc;

    // Clamp the column count to the supported range
    always_comb begin
        cfg_ext = WW'(r_cols);
        if (cfg_ext < WW'(MIN_COLUMNS)) begin
            w_full = WW'(MIN_COLUMNS);
        end else if (cfg_ext > WW'(MAX_COLUMNS)) begin
            w_full = WW'(MAX_COLUMNS);
        end else begin
            w_full = cfg_ext;
        end
        w = CW'(w_full);
    end

    // Current column, wrapped if the count shrank
    assign c     = (CW'(r_col) >= w) ? '0 : r_col;
    assign c_inc = CW'(c) + CW'(1);

    // Drain bookkeeping
    always_comb begin
        if (r_rows == 2'd0) begin
            pending = DW'(c);
        end else if ((r_rows == 2'd1) && (c == '0)) begin
            pending = DW'(w);
        end else begin
            pending = DW'(w) + DW'(1);
        end
        dl_cur   = (r_drain == '0) ? pending : r_drain;
        dl_next  = dl_cur - DW'(1);
        k        = DW'(w) + DW'(1) - dl_cur;
        idx_sum  = (DW+1)'(c) + (DW+1)'(k) - (DW+1)'(1);
        idx_wrap = (idx_sum >= (DW+1)'(w)) ? (idx_sum - (DW+1)'(w)) : idx_sum;
    end

    // Next state and stage decisions for one accepted item
    always_comb begin
        n_col   = r_col;
        n_rows  = r_rows;
        n_drain = r_drain;
        n_ctrl  = '{kind: KIND_NONE, emit: 1'b0, use_centre: 1'b0, last: 1'b0};
        if (i_item.mode == MODE_DRAIN) begin
            if (!((r_drain == '0) && (pending == '0))) begin
                n_drain           = dl_next;
                n_ctrl.kind       = KIND_DRAIN;
                n_ctrl.emit       = 1'b1;
                n_ctrl.use_centre = (k == '0);
                n_ctrl.last       = (dl_next == '0);
                if (dl_next == '0) begin
                    n_col  = '0;
                    n_rows = 2'd0;
                end
            end
        end else if (r_drain == '0) begin
            n_ctrl.kind       = KIND_PUSH;
            n_ctrl.emit       = ((c != '0) && (r_rows != 2'd0)) ||
                                ((c == '0) && (r_rows == 2'd2));
            n_ctrl.use_centre = (r_rows == 2'd1) || (c == ADDR_W'(1)) || (c == '0);
            if (c_inc == w) begin
                n_col = '0;
                if (r_rows != 2'd2) begin
                    n_rows = r_rows + 2'd1;
                end
            end else begin
                n_col = ADDR_W'(c_inc);
            end
        end
    end

    // Read the drained cell, or the column being pushed
    assign o_rd_addr = (i_item.mode == MODE_DRAIN) ? ADDR_W'(idx_wrap) : c;

    // Frame state; a register write starts a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COLUMNS_RST;
            r_col   <= '0;
            r_rows  <= 2'd0;
            r_drain <= '0;
        end else if (i_cfg_we) begin
            r_cols  <= i_cfg_data;
            r_col   <= '0;
            r_rows  <= 2'd0;
            r_drain <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_drain <= n_drain;
        end
    end

    // Stage register toward the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctrl   <= n_ctrl;
            r_s1_addr   <= c;
            r_s1_sample <= i_item.sample;
        end
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1_ctrl   = r_s1_ctrl;
    assign o_s1_addr   = r_s1_addr;
    assign o_s1_sample = r_s1_sample;

endmodule

FILE: sv/hsfp_window.sv
// ----------------------------------------------------------------------------
// hsfp_window
// Compute stage: stencil window registers, the five-point sum, line store
// write-back, and the output register toward the result channel.
// ----------------------------------------------------------------------------
module hsfp_window
    import hsfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_s1_valid,
    input  t_s1_ctrl         i_s1_ctrl,
    input  logic [VAL_W-1:0] i_s1_sample,
    input  logic [VAL_W-1:0] i_top,
    input  logic [VAL_W-1:0] i_mid,
    input  logic             i_out_stall,
    output logic             o_s1_fire,
    output logic             o_store_we,
    output logic [VAL_W-1:0] o_upper_wd,
    output logic [VAL_W-1:0] o_middle_wd,
    output logic             o_out_valid,
    output t_out_item        o_out_item
);

    logic [VAL_W-1:0] r_north;
    logic [VAL_W-1:0] r_centre;
    logic [VAL_W-1:0] r_west;
    logic [VAL_W-1:0] r_south;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             out_free;
    logic             push_fire;
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] value;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_s1_fire  = i_s1_valid && out_free;
    assign push_fire  = o_s1_fire && (i_s1_ctrl.kind == KIND_PUSH);

    // Five-point sum, centre weighted twice
    assign sum = SUM_W'(r_north) + SUM_W'(r_south) + (SUM_W'(r_centre) << 1)
               + SUM_W'(i_mid) + SUM_W'(r_west);

    // Select the result: passthrough, drained cell, or weighted sum over eight
    always_comb begin
        if (i_s1_ctrl.use_centre) begin
            value = r_centre;
        end else if (i_s1_ctrl.kind == KIND_DRAIN) begin
            value = i_mid;
        end else begin
            value = sum[SUM_W-1:3];
        end
    end

    // Write back: middle row moves up, new sample enters the middle row
    assign o_store_we  = push_fire;
    assign o_upper_wd  = i_mid;
    assign o_middle_wd = i_s1_sample;

    // Advance the window on a push; clear it at frame start and last drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_north  <= '0;
            r_centre <= '0;
            r_west   <= '0;
            r_south  <= '0;
        end else if (push_fire) begin
            r_west   <= r_centre;
            r_centre <= i_mid;
            r_north  <= i_top;
            r_south  <= i_s1_sample;
        end else if (o_s1_fire && (i_s1_ctrl.kind == KIND_DRAIN) && i_s1_ctrl.last) begin
            r_north  <= '0;
            r_centre <= '0;
            r_west   <= '0;
            r_south  <= '0;
        end
    end

    // Output register; hold while the result side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s1_fire && i_s1_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_fire && i_s1_ctrl.emit) begin
            r_out_item.cell_value <= value;
            r_out_item.frame_end  <= (i_s1_ctrl.kind == KIND_DRAIN) && i_s1_ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
